### rtl/shri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shri_pkg
// Shared widths, codes and types of the spectral history ring interpolator.
// ----------------------------------------------------------------------------
package shri_pkg;

   localparam int CFG_W     = 9;
   localparam int MAG_W     = 24;
   localparam int AGE_W     = 16;
   localparam int BIN_W     = 9;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;
   localparam logic [CFG_W-1:0] WIN_RESET = 9'd256;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FROZEN   = 2'd0,
      CSR_CAPACITY = 2'd1,
      CSR_WINDOW   = 2'd2
   } csr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage
`default_nettype wire

### rtl/shri_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shri_req_if / shri_rsp_if
// Valid/ready channels for requests and interpolated results.
// ----------------------------------------------------------------------------
interface shri_req_if import shri_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BIN_W-1:0]  bin_index;
   logic [MAG_W-1:0]  magnitude_in;
   logic              frame_last;
   logic [AGE_W-1:0]  age_fraction;

   modport source (output valid, kind, bin_index, magnitude_in, frame_last, age_fraction,
                   input ready);
   modport sink (input valid, kind, bin_index, magnitude_in, frame_last, age_fraction,
                 output ready);
endinterface

interface shri_rsp_if import shri_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude_out;
   logic [BIN_W-1:0] bin_out;

   modport source (output valid, magnitude_out, bin_out, input ready);
   modport sink (input valid, magnitude_out, bin_out, output ready);
endinterface
`default_nettype wire

### rtl/spectral_history_ring_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_history_ring_interpolator
// Ring of spectral frames with a linearly interpolated read across frame age.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    kind, bin_index, magnitude_in, frame_last,
//                               age_fraction
//  rsp      out  valid/ready    magnitude_out, bin_out
//  csr      in   csr_we         csr_index, csr_wdata
//
//  Each pointer or age reduction that falls at or above the capacity goes
//  through the shared remainder unit.
//  Clear: all CAPACITY*BINS store entries, one zeroed per cycle.
//  Reset clears control state; store contents are undefined until written.
//  req.ready is high only between requests; a finished result waits in the
//  rsp register and the next request is taken while it stalls.
// ----------------------------------------------------------------------------
module spectral_history_ring_interpolator import shri_pkg::*; #(
   parameter int BINS     = 512,
   parameter int CAPACITY = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   shri_req_if.sink                  req,
   shri_rsp_if.source                rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int PTR_W   = $clog2(CAPACITY);
   localparam int WP_W    = (PTR_W < CFG_W) ? PTR_W : CFG_W;
   localparam int DEPTH   = CAPACITY * BINS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int MUL_A_W = MAG_W + 1;
   localparam int MUL_B_W = AGE_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_AGE,
      S_WPMOD,
      S_WRITE,
      S_A0MOD,
      S_RDA,
      S_A1MOD,
      S_RDB,
      S_MIX,
      S_SUM,
      S_ZERO,
      S_CLEAR
   } state_type;

   state_type state_ff;

   logic             frozen_ff;
   logic [CFG_W-1:0] cap_reg_ff;
   logic [CFG_W-1:0] win_reg_ff;

   logic [WP_W-1:0]  wp_ff;
   logic [CFG_W-1:0] held_ff;

   logic [KIND_W-1:0] kind_ff;
   logic [BIN_W-1:0]  bin_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              last_ff;
   logic [AGE_W-1:0]  agef_ff;

   logic [CFG_W-1:0]  age0_ff;
   logic [CFG_W-1:0]  age1_ff;
   logic [AGE_W-1:0]  frac_ff;
   logic [CFG_W-1:0]  wpm_ff;
   logic [CFG_W-1:0]  newest_ff;
   logic [CFG_W-1:0]  slot_ff;
   logic [MAG_W-1:0]  mag_a_ff;
   logic              launched_ff;
   logic [ADDR_W-1:0] clr_ff;

   logic signed [PROD_W-1:0] prod_ff;

   logic             rsp_valid_ff;
   logic [MAG_W-1:0] rsp_mag_ff;
   logic [BIN_W-1:0] rsp_bin_ff;

   logic [CFG_W-1:0] cap;
   logic [CFG_W-1:0] win;
   logic [CFG_W-1:0] active;
   logic [CFG_W-1:0] activem1;
   logic             req_bin_ok;
   logic             bin_ok;

   logic             in_mod;
   logic             mod_fast;
   logic             mod_take;
   logic [CFG_W-1:0] mod_x;
   logic [CFG_W-1:0] mod_val;
   logic [CFG_W-1:0] slot_new;
   logic             rem_start;
   rem_status_type   rem_stat;
   logic [CFG_W-1:0] rem_val;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  rnd;
   logic signed [MUL_A_W-1:0] diff;
   logic [CFG_W-1:0]          age0_w;
   logic [CFG_W-1:0]          age0_inc;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [MAG_W-1:0]  mem_wr_data;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [MAG_W-1:0]  mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff  <= 1'b0;
         cap_reg_ff <= CAP_RESET;
         win_reg_ff <= WIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FROZEN:   frozen_ff  <= csr_wdata[0];
            CSR_CAPACITY: cap_reg_ff <= csr_wdata;
            CSR_WINDOW:   win_reg_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      cap        = (32'(cap_reg_ff) > CAPACITY) ? CFG_W'(CAPACITY) : cap_reg_ff;
      win        = (win_reg_ff == '0) ? CFG_W'(1) : win_reg_ff;
      active     = (held_ff < win) ? held_ff : win;
      activem1   = active - 1'b1;
      req_bin_ok = 32'(req.bin_index) < BINS;
      bin_ok     = 32'(bin_ff) < BINS;
      age0_w     = prod_ff[AGE_W +: CFG_W];
      age0_inc   = age0_w + 1'b1;
   end

   // remainder sequencing
   always_comb begin
      case (state_ff)
         S_WPMOD: mod_x = CFG_W'(wp_ff);
         S_A0MOD: mod_x = age0_ff;
         S_A1MOD: mod_x = age1_ff;
         default: mod_x = age0_ff;
      endcase
      in_mod    = (state_ff == S_WPMOD) || (state_ff == S_A0MOD) || (state_ff == S_A1MOD);
      mod_fast  = mod_x < cap;
      rem_start = in_mod && !launched_ff && !mod_fast && !rem_stat.busy;
      mod_take  = in_mod && ((!launched_ff && mod_fast) || rem_stat.done);
      mod_val   = launched_ff ? rem_val : mod_x;
      slot_new  = (newest_ff >= mod_val) ? (newest_ff - mod_val)
                                         : (newest_ff + cap - mod_val);
   end

   shri_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (mod_x),
      .divisor   (cap),
      .status    (rem_stat),
      .remainder (rem_val)
   );

   // shared multiplier
   always_comb begin
      diff = $signed({1'b0, mem_rd_data}) - $signed({1'b0, mag_a_ff});
      if (state_ff == S_MIX) begin
         mul_a = diff;
         mul_b = $signed({1'b0, frac_ff});
      end else begin
         mul_a = $signed({{(MUL_A_W - CFG_W){1'b0}}, activem1});
         mul_b = $signed({1'b0, agef_ff});
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
      rnd   = (prod_ff + PROD_W'(32'sd32768)) >>> AGE_W;
   end

   // frame store
   always_comb begin
      mem_we      = (state_ff == S_CLEAR) || ((state_ff == S_WRITE) && bin_ok);
      mem_wr_addr = (state_ff == S_CLEAR) ? clr_ff
                  : ADDR_W'(ADDR_W'(wpm_ff) * ADDR_W'(BINS) + ADDR_W'(bin_ff));
      mem_wr_data = (state_ff == S_CLEAR) ? '0 : mag_ff;
      mem_re      = (state_ff == S_RDA) || (state_ff == S_RDB);
      mem_rd_addr = ADDR_W'(ADDR_W'(slot_ff) * ADDR_W'(BINS) + ADDR_W'(bin_ff));
   end

   shri_ram #(
      .WIDTH (MAG_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         held_ff      <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_SUM) && (state_ff != S_ZERO)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rem_start) begin
            launched_ff <= 1'b1;
         end
         if (mod_take) begin
            launched_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  kind_ff <= req.kind;
                  bin_ff  <= req.bin_index;
                  mag_ff  <= req.magnitude_in;
                  last_ff <= req.frame_last;
                  agef_ff <= req.age_fraction;
                  clr_ff  <= '0;
                  case (req.kind)
                     KIND_WRITE: begin
                        if (!frozen_ff && (cap != '0)) begin
                           state_ff <= S_WPMOD;
                        end
                     end
                     KIND_READ: begin
                        if ((active == '0) || (cap == '0) || !req_bin_ok) begin
                           state_ff <= S_ZERO;
                        end else begin
                           state_ff <= S_MUL;
                        end
                     end
                     KIND_CLEAR: state_ff <= S_CLEAR;
                     default:    ;
                  endcase
               end
            end
            S_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_AGE;
            end
            S_AGE: begin
               age0_ff  <= age0_w;
               age1_ff  <= (age0_inc < activem1) ? age0_inc : activem1;
               frac_ff  <= prod_ff[AGE_W-1:0];
               state_ff <= S_WPMOD;
            end
            S_WPMOD: begin
               if (mod_take) begin
                  wpm_ff    <= mod_val;
                  newest_ff <= (mod_val == '0) ? (cap - 1'b1) : (mod_val - 1'b1);
                  state_ff  <= (kind_ff == KIND_WRITE) ? S_WRITE : S_A0MOD;
               end
            end
            S_WRITE: begin
               if (last_ff) begin
                  wp_ff <= (wpm_ff + 1'b1 == cap) ? '0 : WP_W'(wpm_ff + 1'b1);
                  if (held_ff < cap) begin
                     held_ff <= held_ff + 1'b1;
                  end
               end
               state_ff <= S_IDLE;
            end
            S_A0MOD: begin
               if (mod_take) begin
                  slot_ff  <= slot_new;
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               state_ff <= S_A1MOD;
            end
            S_A1MOD: begin
               if (mod_take) begin
                  mag_a_ff <= mem_rd_data;
                  slot_ff  <= slot_new;
                  state_ff <= S_RDB;
               end
            end
            S_RDB: begin
               state_ff <= S_MIX;
            end
            S_MIX: begin
               prod_ff  <= mul_p;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mag_ff   <= mag_a_ff + rnd[MAG_W-1:0];
                  rsp_bin_ff   <= bin_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_ZERO: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mag_ff   <= '0;
                  rsp_bin_ff   <= bin_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  wp_ff    <= '0;
                  held_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.magnitude_out = rsp_mag_ff;
   assign rsp.bin_out       = rsp_bin_ff;

endmodule
`default_nettype wire

### rtl/shri_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shri_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shri_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 131072
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/shri_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shri_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shri_rem import shri_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CFG_W-1:0] dividend,
   input  wire logic [CFG_W-1:0] divisor,
   output rem_status_type        status,
   output logic      [CFG_W-1:0] remainder
);

   localparam int CNT_W = $clog2(CFG_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CFG_W-1:0] dvd_ff;
   logic [CFG_W-1:0] div_ff;
   logic [CFG_W-1:0] rem_ff;
   logic [CFG_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[CFG_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            div_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (trial >= {1'b0, div_ff}) begin
               rem_ff <= CFG_W'(trial - {1'b0, div_ff});
            end else begin
               rem_ff <= trial[CFG_W-1:0];
            end
            dvd_ff <= {dvd_ff[CFG_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CFG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule
`default_nettype wire

### rtl/shri_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shri_checker
// Port-level checks of the spectral history ring interpolator.
// ----------------------------------------------------------------------------
module shri_checker import shri_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [KIND_W-1:0] req_kind,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_READ) |=> !req_ready)
      else $error("request taken while a read is in progress");

   a_no_write_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_WRITE || req_kind == KIND_CLEAR)
      |=> !$rose(rsp_valid))
      else $error("result produced for a write or clear request");

endmodule

bind spectral_history_ring_interpolator shri_checker u_shri_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_kind  (req.kind),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
`default_nettype wire
